/* hdl/gsr_pkg.sv */
// ----------------------------------------------------------------------------
// gsr_pkg: shared types and constants for the gamepad serial responder
// Request payload types, operation and command codes, and the fixed reply
// tables used by the pad side of the nine-byte poll exchange.
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam int FRAME_LEN = 9;

  localparam logic [1:0] OP_EXCHANGE     = 2'd0;
  localparam logic [1:0] OP_RESET        = 2'd1;
  localparam logic [1:0] OP_FORCE_ANALOG = 2'd2;

  localparam logic [7:0] MODE_ID_DIG = 8'h41;
  localparam logic [7:0] MODE_ID_ANA = 8'h73;
  localparam logic [7:0] MODE_ID_CFG = 8'hF3;
  localparam logic [7:0] SYNC_BYTE  = 8'h5A;
  localparam logic [7:0] FILL_BYTE  = 8'hFF;
  localparam logic [2:0] SLOT_NONE  = 3'd7;

  localparam logic [7:0] CMD_STATUS    = 8'h40;
  localparam logic [7:0] CMD_POLL      = 8'h42;
  localparam logic [7:0] CMD_CONFIG    = 8'h43;
  localparam logic [7:0] CMD_SET_MODE  = 8'h44;
  localparam logic [7:0] CMD_MODEL     = 8'h45;
  localparam logic [7:0] CMD_ID_A      = 8'h46;
  localparam logic [7:0] CMD_ID_B      = 8'h47;
  localparam logic [7:0] CMD_ID_C      = 8'h4C;
  localparam logic [7:0] CMD_RUMBLE_MAP = 8'h4D;

  localparam logic [7:0] MODEL_TABLE [6] = '{8'h03, 8'h02, 8'h00, 8'h02, 8'h01, 8'h00};
  localparam logic [7:0] STATUS_TABLE [6] = '{8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h5A};
  localparam logic [7:0] ID_TABLE [5][5] = '{
    '{8'h00, 8'h01, 8'h02, 8'h00, 8'h0A},
    '{8'h00, 8'h01, 8'h01, 8'h01, 8'h14},
    '{8'h00, 8'h02, 8'h00, 8'h01, 8'h00},
    '{8'h00, 8'h00, 8'h04, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h07, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  port;
    logic [3:0]  byte_index;
    logic [7:0]  command_byte;
    logic [15:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
  } gsr_in_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       rumble_fire;
    logic [7:0] rumble_small;
    logic [7:0] rumble_big;
  } gsr_out_t;

endpackage

/* hdl/gamepad_serial_responder.sv */
// ----------------------------------------------------------------------------
// gamepad_serial_responder: pad side of a nine-byte serial poll exchange
// Requests arrive on in_valid/in_ready/in_data (gsr_in_t): exchange one byte,
// reset a port or force analog mode. Every request gives exactly one result
// on out_valid/out_ready/out_data (gsr_out_t): the reply byte for that byte
// position plus, at byte 8 of a poll, the two rumble strengths.
// A request is taken into an input register; from there the per-port
// table and compare logic runs, updates that port's buffers and loads the result
// register as soon as the result register is free (empty or being taken).
// Throughput is one request per cycle while out_ready stays high; a held
// result stops the flow, as described below.
// Reset (rst_n low, synchronous) puts every port in analog mode, clears the
// config flag and motor mappings, fills the reply buffer with 0xFF (byte 2
// 0x5A) and clears the received buffer. No results are pending after reset.
// When out_ready is low the result is held; one more request may wait in the
// input register, after which in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module gamepad_serial_responder
  import gsr_pkg::*;
#(
  parameter int PORT_COUNT = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  gsr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output gsr_out_t out_data
);

  localparam logic [3:0] PORT_LIMIT = 4'(PORT_COUNT);

  logic     in_valid_r;
  gsr_in_t  in_r;
  logic     out_valid_r;
  gsr_out_t out_r;

  logic [7:0] reply_r    [PORT_COUNT][FRAME_LEN];
  logic [7:0] received_r [PORT_COUNT][FRAME_LEN];
  logic       analog_r   [PORT_COUNT];
  logic       cfg_r      [PORT_COUNT];
  logic [2:0] small_r    [PORT_COUNT];
  logic [2:0] big_r      [PORT_COUNT];

  logic [7:0] r_cur [FRAME_LEN];
  logic [7:0] c_cur [FRAME_LEN];
  logic       am_cur, ca_cur;
  logic [2:0] ss_cur, bs_cur;

  logic [7:0] r_nxt [FRAME_LEN];
  logic [7:0] c_nxt [FRAME_LEN];
  logic       am_nxt, ca_nxt;
  logic [2:0] ss_nxt, bs_nxt;

  logic     advance;
  logic     port_ok, idx_ok, row_wr;
  logic [7:0] cmd;
  logic [3:0] small_idx, big_idx;
  gsr_out_t out_nxt;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign port_ok = {1'b0, in_r.port} < PORT_LIMIT;
  assign idx_ok  = in_r.byte_index < 4'(FRAME_LEN);

  // current row of the addressed port
  always_comb begin
    for (int b = 0; b < FRAME_LEN; b++) begin
      r_cur[b] = reply_r[0][b];
      c_cur[b] = received_r[0][b];
    end
    am_cur = analog_r[0];
    ca_cur = cfg_r[0];
    ss_cur = small_r[0];
    bs_cur = big_r[0];
    for (int i = 1; i < PORT_COUNT; i++) begin
      if (in_r.port == 3'(i)) begin
        for (int b = 0; b < FRAME_LEN; b++) begin
          r_cur[b] = reply_r[i][b];
          c_cur[b] = received_r[i][b];
        end
        am_cur = analog_r[i];
        ca_cur = cfg_r[i];
        ss_cur = small_r[i];
        bs_cur = big_r[i];
      end
    end
  end

  always_comb begin
    r_nxt   = r_cur;
    c_nxt   = c_cur;
    am_nxt  = am_cur;
    ca_nxt  = ca_cur;
    ss_nxt  = ss_cur;
    bs_nxt  = bs_cur;
    row_wr  = 1'b0;
    out_nxt = '0;
    cmd     = c_cur[1];
    small_idx = 4'({1'b0, ss_cur}) + 4'd3;
    big_idx   = 4'({1'b0, bs_cur}) + 4'd3;

    case (in_r.op)
      OP_RESET: begin
        row_wr = port_ok;
        for (int b = 0; b < FRAME_LEN; b++) begin
          r_nxt[b] = FILL_BYTE;
          c_nxt[b] = 8'h00;
        end
        r_nxt[2] = SYNC_BYTE;
        am_nxt   = 1'b1;
        ca_nxt   = 1'b0;
        ss_nxt   = SLOT_NONE;
        bs_nxt   = SLOT_NONE;
      end
      OP_FORCE_ANALOG: begin
        row_wr = port_ok;
        am_nxt = 1'b1;
      end
      OP_EXCHANGE: begin
        if (!port_ok) begin
          out_nxt.reply_byte = FILL_BYTE;
        end else if (idx_ok) begin
          row_wr = 1'b1;
          c_nxt[in_r.byte_index] = in_r.command_byte;
          case (in_r.byte_index)
            4'd1: begin
              cmd = in_r.command_byte;
              r_nxt[1] = ca_cur ? MODE_ID_CFG : (am_cur ? MODE_ID_ANA : MODE_ID_DIG);
              case (cmd)
                CMD_STATUS: begin
                  if (ca_cur) begin
                    for (int b = 0; b < 6; b++) r_nxt[b+3] = STATUS_TABLE[b];
                  end
                end
                CMD_POLL, CMD_CONFIG: begin
                  if (ca_cur) begin
                    for (int b = 3; b < FRAME_LEN; b++) begin
                      r_nxt[b] = (cmd == CMD_POLL) ? FILL_BYTE : 8'h00;
                    end
                  end else begin
                    r_nxt[3] = in_r.buttons[7:0];
                    r_nxt[4] = in_r.buttons[15:8];
                    if (am_cur) begin
                      r_nxt[5] = in_r.right_x;
                      r_nxt[6] = in_r.right_y;
                      r_nxt[7] = in_r.left_x;
                      r_nxt[8] = in_r.left_y;
                    end else begin
                      for (int b = 5; b < FRAME_LEN; b++) r_nxt[b] = FILL_BYTE;
                    end
                  end
                end
                CMD_SET_MODE: begin
                  for (int b = 3; b < FRAME_LEN; b++) r_nxt[b] = 8'h00;
                end
                CMD_MODEL: begin
                  if (ca_cur) begin
                    for (int b = 0; b < 6; b++) r_nxt[b+3] = MODEL_TABLE[b];
                    r_nxt[5] = {7'd0, am_cur};
                  end
                end
                CMD_ID_A, CMD_ID_B, CMD_ID_C: begin
                  if (ca_cur) r_nxt[3] = 8'h00;
                end
                CMD_RUMBLE_MAP: begin
                  if (ca_cur) begin
                    r_nxt[3] = (ss_cur == SLOT_NONE) ? FILL_BYTE : {5'd0, ss_cur};
                    r_nxt[4] = (bs_cur == SLOT_NONE) ? FILL_BYTE : {5'd0, bs_cur};
                    for (int b = 5; b < FRAME_LEN; b++) r_nxt[b] = FILL_BYTE;
                  end
                end
                default: ;
              endcase
            end
            4'd2: r_nxt[2] = SYNC_BYTE;
            4'd4: begin
              case (cmd)
                CMD_CONFIG:   ca_nxt = (c_cur[3] == 8'h01);
                CMD_SET_MODE: if (ca_cur) am_nxt = (c_cur[3] == 8'h01);
                CMD_ID_A: begin
                  if (ca_cur) begin
                    for (int b = 0; b < 5; b++) begin
                      r_nxt[b+4] = ID_TABLE[(c_cur[3] == 8'h00) ? 0 : 1][b];
                    end
                  end
                end
                CMD_ID_B: begin
                  if (ca_cur) begin
                    for (int b = 0; b < 5; b++) r_nxt[b+4] = ID_TABLE[2][b];
                  end
                end
                CMD_ID_C: begin
                  if (ca_cur) begin
                    for (int b = 0; b < 5; b++) begin
                      r_nxt[b+4] = ID_TABLE[(c_cur[3] == 8'h00) ? 3 : 4][b];
                    end
                  end
                end
                default: ;
              endcase
            end
            4'd8: begin
              if (cmd == CMD_POLL) begin
                out_nxt.rumble_fire = 1'b1;
                if (ss_cur < 3'd6) out_nxt.rumble_small = c_nxt[small_idx];
                if (bs_cur < 3'd6) out_nxt.rumble_big   = c_nxt[big_idx];
              end else if (cmd == CMD_RUMBLE_MAP) begin
                ss_nxt = SLOT_NONE;
                bs_nxt = SLOT_NONE;
                for (int b = 3; b < FRAME_LEN; b++) begin
                  if (c_nxt[b] == 8'h00) ss_nxt = 3'(b - 3);
                  if (c_nxt[b] == 8'h01) bs_nxt = 3'(b - 3);
                end
              end
            end
            default: ;
          endcase
          out_nxt.reply_byte = r_nxt[in_r.byte_index];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        for (int b = 0; b < FRAME_LEN; b++) begin
          reply_r[i][b]    <= (b == 2) ? SYNC_BYTE : FILL_BYTE;
          received_r[i][b] <= 8'h00;
        end
        analog_r[i] <= 1'b1;
        cfg_r[i]    <= 1'b0;
        small_r[i]  <= SLOT_NONE;
        big_r[i]    <= SLOT_NONE;
      end
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance && row_wr) begin
        for (int i = 0; i < PORT_COUNT; i++) begin
          if (in_r.port == 3'(i)) begin
            for (int b = 0; b < FRAME_LEN; b++) begin
              reply_r[i][b]    <= r_nxt[b];
              received_r[i][b] <= c_nxt[b];
            end
            analog_r[i] <= am_nxt;
            cfg_r[i]    <= ca_nxt;
            small_r[i]  <= ss_nxt;
            big_r[i]    <= bs_nxt;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule
